// ===== rtl/core/wfe_pkg.sv =====
// shared types and constants for the 3x3 window edge filter
// used by every module of the block but wfe_ram; no dependencies

package wfe_pkg;

    typedef logic [7:0] pix_t;

    // window laid out row by row, entry r*3+c
    typedef pix_t [8:0] win_t;

    typedef enum logic [2:0] {
        MODE_BOX         = 3'd0,
        MODE_GAUSS       = 3'd1,
        MODE_PREWITT_X   = 3'd2,
        MODE_PREWITT_Y   = 3'd3,
        MODE_SOBEL_X     = 3'd4,
        MODE_SOBEL_Y     = 3'd5,
        MODE_PREWITT_MAX = 3'd6,
        MODE_SOBEL_MAX   = 3'd7
    } mode_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 10;
    localparam int COORD_W    = 10;
    localparam int SUM_W      = 12;
    localparam int GRAD_W     = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARIZE_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd4;

    localparam mode_t            RST_FILTER_MODE = MODE_SOBEL_MAX;
    localparam logic             RST_BINARIZE    = 1'b1;
    localparam pix_t             RST_THRESHOLD   = 8'd40;
    localparam logic [DIM_W-1:0] RST_WIDTH       = 11'd512;
    localparam logic [DIM_W-1:0] RST_HEIGHT      = 11'd512;
    localparam logic [DIM_W-1:0] MIN_DIM         = 11'd3;
    localparam logic [DIM_W-1:0] MAX_HEIGHT      = 11'd1024;

    // floor(s*0.1111) == (s*BOX_RECIP) >> BOX_SHIFT for every nine-pixel sum
    localparam logic [21:0] BOX_RECIP  = 22'd3727898;
    localparam int          BOX_SHIFT  = 25;
    // floor(m/3) == (m*DIV3_RECIP) >> DIV3_SHIFT for m up to 1020
    localparam logic [9:0]  DIV3_RECIP = 10'd683;
    localparam int          DIV3_SHIFT = 11;

    typedef struct packed {
        mode_t            filter_mode;
        logic             binarize_enable;
        pix_t             threshold;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0]         box_sum;
        logic [SUM_W-1:0]         gauss_sum;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
    } sums_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               frame_end;
    } meta_t;

endpackage

// ===== rtl/core/window_filter_3x3_edge.sv =====
// streaming 3x3 window filter: box, gauss, prewitt and sobel edge responses
// path: an accepted pixel passes stage 1, stage 2 and the result register to the m_ ports
// throughput: one pixel per cycle if m_ready is high, set by one ram read and write per cycle
// border pixels produce no result; each interior pixel produces exactly one
// reset (aresetn, synchronous, active low) clears counters, window, pipeline valids and
// config to defaults; line stores are not cleared and need no clearing pass

module window_filter_3x3_edge #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfe_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_value,
    output logic [wfe_pkg::COORD_W-1:0]    m_out_row,
    output logic [wfe_pkg::COORD_W-1:0]    m_out_col,
    output logic                           m_frame_end
);

    wfe_pkg::cfg_t  cfg;
    wfe_pkg::sums_t sums;
    wfe_pkg::meta_t meta;
    logic           sums_valid;
    logic           sums_ready;

    wfe_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    wfe_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .pix_valid  (s_valid),
        .pix_ready  (s_ready),
        .pixel      (s_pixel),
        .sums_valid (sums_valid),
        .sums_ready (sums_ready),
        .sums       (sums),
        .meta       (meta)
    );

    wfe_post u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .sums_valid  (sums_valid),
        .sums_ready  (sums_ready),
        .sums        (sums),
        .meta        (meta),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_frame_end (m_frame_end)
    );

endmodule

// ===== rtl/core/wfe_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module wfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/wfe_cfg.sv =====
// configuration registers of the window filter
// depends on wfe_pkg

module wfe_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfe_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output wfe_pkg::cfg_t                  cfg
);

    wfe_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_mode     <= wfe_pkg::RST_FILTER_MODE;
            cfg_reg.binarize_enable <= wfe_pkg::RST_BINARIZE;
            cfg_reg.threshold       <= wfe_pkg::RST_THRESHOLD;
            cfg_reg.image_width     <= wfe_pkg::RST_WIDTH;
            cfg_reg.image_height    <= wfe_pkg::RST_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                wfe_pkg::CFG_FILTER_MODE: begin
                    cfg_reg.filter_mode <= wfe_pkg::mode_t'(cfg_wr_data[2:0]);
                end
                wfe_pkg::CFG_BINARIZE_ENABLE: begin
                    cfg_reg.binarize_enable <= cfg_wr_data[0];
                end
                wfe_pkg::CFG_THRESHOLD: begin
                    cfg_reg.threshold <= cfg_wr_data[7:0];
                end
                wfe_pkg::CFG_IMAGE_WIDTH: begin
                    cfg_reg.image_width <= cfg_wr_data;
                end
                wfe_pkg::CFG_IMAGE_HEIGHT: begin
                    cfg_reg.image_height <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/wfe_window.sv =====
// raster counters, line store ram, 3x3 window and kernel sum stage
// depends on wfe_pkg and wfe_ram

module wfe_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wfe_pkg::cfg_t         cfg,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  wfe_pkg::pix_t         pixel,
    output logic                  sums_valid,
    input  logic                  sums_ready,
    output wfe_pkg::sums_t        sums,
    output wfe_pkg::meta_t        meta
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > wfe_pkg::DIM_W) ?
                        $clog2(MAX_WIDTH + 1) : wfe_pkg::DIM_W;

    // raster position of the next pixel
    logic [AW-1:0]               col_reg;
    logic [wfe_pkg::ROW_W-1:0]   row_reg;

    // stage 1: pixel waiting for its line store data
    logic                        v1_reg;
    wfe_pkg::pix_t               pix1_reg;
    logic [AW-1:0]               col1_reg;
    logic                        emit1_reg;
    wfe_pkg::meta_t              meta1_reg;

    // stage 2: kernel sums of an interior pixel
    logic                        v2_reg;
    logic                        v2_next;
    wfe_pkg::sums_t              sums_reg;
    wfe_pkg::meta_t              meta2_reg;

    wfe_pkg::win_t               win_reg;
    wfe_pkg::win_t               win_next;
    wfe_pkg::sums_t              sums_next;

    logic                        s_fire;
    logic                        s1_fire;
    logic                        s2_fire;
    logic                        s2_free;

    logic [WW-1:0]               width_ext;
    logic [WW-1:0]               width_clamped;
    logic [wfe_pkg::DIM_W-1:0]   height_clamped;
    logic                        last_col;
    logic                        last_row;
    logic                        emit;
    logic [AW-1:0]               col_m1;
    logic [AW+wfe_pkg::COORD_W-1:0] col_m1_ext;
    logic [wfe_pkg::ROW_W-1:0]   row_m1;

    logic [15:0]                 rd_data;
    wfe_pkg::pix_t               top_pix;
    wfe_pkg::pix_t               mid_pix;
    logic                        sobel;
    logic signed [wfe_pkg::GRAD_W-1:0] dx0, dx1, dx2, dy0, dy1, dy2;

    // handshake chain
    assign s2_fire   = v2_reg && sums_ready;
    assign s2_free   = !v2_reg || sums_ready;
    assign s1_fire   = v1_reg && s2_free;
    assign pix_ready = !v1_reg || s2_free;
    assign s_fire    = pix_valid && pix_ready;

    // frame geometry
    assign width_ext = WW'(cfg.image_width);
    always_comb begin
        if (width_ext < WW'(wfe_pkg::MIN_DIM)) begin
            width_clamped = WW'(wfe_pkg::MIN_DIM);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            width_clamped = WW'(MAX_WIDTH);
        end else begin
            width_clamped = width_ext;
        end
        if (cfg.image_height < wfe_pkg::MIN_DIM) begin
            height_clamped = wfe_pkg::MIN_DIM;
        end else if (cfg.image_height > wfe_pkg::MAX_HEIGHT) begin
            height_clamped = wfe_pkg::MAX_HEIGHT;
        end else begin
            height_clamped = cfg.image_height;
        end
    end

    assign last_col   = WW'(col_reg) >= (width_clamped - WW'(1));
    assign last_row   = {1'b0, row_reg} >= (height_clamped - 11'd1);
    assign emit       = (row_reg >= 10'd2) && (col_reg >= AW'(2));
    assign col_m1     = col_reg - AW'(1);
    assign col_m1_ext = {{wfe_pkg::COORD_W{1'b0}}, col_m1};
    assign row_m1     = row_reg - 10'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_fire) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 10'd1;
            end else begin
                col_reg <= col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_fire) begin
            v1_reg <= 1'b1;
        end else if (s1_fire) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pix1_reg            <= pixel;
            col1_reg            <= col_reg;
            emit1_reg           <= emit;
            meta1_reg.out_row   <= row_m1;
            meta1_reg.out_col   <= col_m1_ext[wfe_pkg::COORD_W-1:0];
            meta1_reg.frame_end <= last_col && last_row;
        end
    end

    // upper byte holds the row before the previous one, lower byte the previous row
    wfe_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (col1_reg),
        .wr_data ({mid_pix, pix1_reg}),
        .rd_en   (s_fire),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    assign top_pix = rd_data[15:8];
    assign mid_pix = rd_data[7:0];

    always_comb begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = top_pix;
        win_next[5] = mid_pix;
        win_next[8] = pix1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s1_fire) begin
            win_reg <= win_next;
        end
    end

    // kernel sums on the shifted window
    assign sobel = (cfg.filter_mode == wfe_pkg::MODE_SOBEL_X) ||
                   (cfg.filter_mode == wfe_pkg::MODE_SOBEL_Y) ||
                   (cfg.filter_mode == wfe_pkg::MODE_SOBEL_MAX);

    assign dx0 = $signed({3'b000, win_next[2]}) - $signed({3'b000, win_next[0]});
    assign dx1 = $signed({3'b000, win_next[5]}) - $signed({3'b000, win_next[3]});
    assign dx2 = $signed({3'b000, win_next[8]}) - $signed({3'b000, win_next[6]});
    assign dy0 = $signed({3'b000, win_next[6]}) - $signed({3'b000, win_next[0]});
    assign dy1 = $signed({3'b000, win_next[7]}) - $signed({3'b000, win_next[1]});
    assign dy2 = $signed({3'b000, win_next[8]}) - $signed({3'b000, win_next[2]});

    always_comb begin
        sums_next.box_sum = 12'(win_next[0]) + 12'(win_next[1]) + 12'(win_next[2])
                          + 12'(win_next[3]) + 12'(win_next[4]) + 12'(win_next[5])
                          + 12'(win_next[6]) + 12'(win_next[7]) + 12'(win_next[8]);
        sums_next.gauss_sum = 12'(win_next[0]) + 12'(win_next[2])
                            + 12'(win_next[6]) + 12'(win_next[8])
                            + ((12'(win_next[1]) + 12'(win_next[3])
                              + 12'(win_next[5]) + 12'(win_next[7])) << 1)
                            + (12'(win_next[4]) << 2);
        sums_next.grad_x = dx0 + (sobel ? (dx1 <<< 1) : dx1) + dx2;
        sums_next.grad_y = dy0 + (sobel ? (dy1 <<< 1) : dy1) + dy2;
    end

    always_comb begin
        if (s1_fire) begin
            v2_next = emit1_reg;
        end else if (s2_fire) begin
            v2_next = 1'b0;
        end else begin
            v2_next = v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            sums_reg  <= sums_next;
            meta2_reg <= meta1_reg;
        end
    end

    assign sums_valid = v2_reg;
    assign sums       = sums_reg;
    assign meta       = meta2_reg;

    // end of a row always wraps the column counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && last_col |=> col_reg == '0)
        else $error("column counter did not wrap at end of row");

    // a new read never hits the column being written back
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s1_fire |-> col_reg != col1_reg)
        else $error("line store read and write collide");

    // a stalled stage 1 keeps its pixel, since the ram read data is not refetched
    assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !s2_free |=> v1_reg && $stable(col1_reg) && $stable(pix1_reg))
        else $error("stage 1 lost its pixel while stalled");

endmodule

// ===== rtl/core/wfe_post.sv =====
// scaling, saturation, mode select, binarization and the result register
// depends on wfe_pkg

module wfe_post (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wfe_pkg::cfg_t                cfg,
    input  logic                         sums_valid,
    output logic                         sums_ready,
    input  wfe_pkg::sums_t               sums,
    input  wfe_pkg::meta_t               meta,
    output logic                         m_valid,
    input  logic                         m_ready,
    output wfe_pkg::pix_t                m_value,
    output logic [wfe_pkg::COORD_W-1:0]  m_out_row,
    output logic [wfe_pkg::COORD_W-1:0]  m_out_col,
    output logic                         m_frame_end
);

    logic                         m_valid_reg;
    wfe_pkg::pix_t                value_reg;
    wfe_pkg::meta_t               meta_reg;

    logic                         fire;
    logic [10:0]                  neg_x;
    logic [10:0]                  neg_y;
    logic [9:0]                   abs_x;
    logic [9:0]                   abs_y;
    logic [19:0]                  prod_x;
    logic [19:0]                  prod_y;
    logic [8:0]                   q_x;
    logic [8:0]                   q_y;
    wfe_pkg::pix_t                sat_x;
    wfe_pkg::pix_t                sat_y;
    wfe_pkg::pix_t                grad_max;
    logic [33:0]                  box_prod;
    logic [8:0]                   box_q;
    wfe_pkg::pix_t                box_val;
    wfe_pkg::pix_t                filt;
    wfe_pkg::pix_t                value_next;

    assign sums_ready = !m_valid_reg || m_ready;
    assign fire       = sums_valid && sums_ready;

    // magnitudes fit in 10 bits, at most 4*255
    assign neg_x = 11'(~sums.grad_x) + 11'd1;
    assign neg_y = 11'(~sums.grad_y) + 11'd1;
    assign abs_x = sums.grad_x[10] ? neg_x[9:0] : sums.grad_x[9:0];
    assign abs_y = sums.grad_y[10] ? neg_y[9:0] : sums.grad_y[9:0];

    assign prod_x = 20'(abs_x) * 20'(wfe_pkg::DIV3_RECIP);
    assign prod_y = 20'(abs_y) * 20'(wfe_pkg::DIV3_RECIP);
    assign q_x    = prod_x[wfe_pkg::DIV3_SHIFT +: 9];
    assign q_y    = prod_y[wfe_pkg::DIV3_SHIFT +: 9];
    assign sat_x  = q_x[8] ? 8'hFF : q_x[7:0];
    assign sat_y  = q_y[8] ? 8'hFF : q_y[7:0];
    assign grad_max = (sat_x > sat_y) ? sat_x : sat_y;

    assign box_prod = 34'(sums.box_sum) * 34'(wfe_pkg::BOX_RECIP);
    assign box_q    = box_prod[wfe_pkg::BOX_SHIFT +: 9];
    assign box_val  = box_q[8] ? 8'hFF : box_q[7:0];

    always_comb begin
        filt = 8'h00;
        unique case (cfg.filter_mode)
            wfe_pkg::MODE_BOX:         filt = box_val;
            wfe_pkg::MODE_GAUSS:       filt = sums.gauss_sum[11:4];
            wfe_pkg::MODE_PREWITT_X:   filt = sat_x;
            wfe_pkg::MODE_SOBEL_X:     filt = sat_x;
            wfe_pkg::MODE_PREWITT_Y:   filt = sat_y;
            wfe_pkg::MODE_SOBEL_Y:     filt = sat_y;
            wfe_pkg::MODE_PREWITT_MAX: filt = grad_max;
            wfe_pkg::MODE_SOBEL_MAX:   filt = grad_max;
            default:                   filt = grad_max;
        endcase
    end

    always_comb begin
        if (cfg.binarize_enable) begin
            value_next = (filt < cfg.threshold) ? 8'h00 : 8'hFF;
        end else begin
            value_next = filt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            value_reg <= value_next;
            meta_reg  <= meta;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = value_reg;
    assign m_out_row   = meta_reg.out_row;
    assign m_out_col   = meta_reg.out_col;
    assign m_frame_end = meta_reg.frame_end;

endmodule
